[rtl/core/mpft_pkg.sv]
package mpft_pkg;

    localparam int PERIPH_DEPTH = 256;
    localparam int ADDR_W       = $clog2(PERIPH_DEPTH);

    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 56;

    typedef enum logic [2:0] {
        FN_READ  = 3'd0,
        FN_WRITE = 3'd1,
        FN_TICK  = 3'd2,
        FN_EVENT = 3'd3,
        FN_LINE  = 3'd4
    } t_func;

    localparam logic [7:0] REG_CTRL   = 8'h00;
    localparam logic [7:0] REG_RELOAD = 8'h02;
    localparam logic [7:0] REG_TCTL   = 8'h03;
    localparam logic [7:0] REG_PA     = 8'h04;
    localparam logic [7:0] REG_PB     = 8'h06;
    localparam logic [7:0] REG_PC     = 8'h08;
    localparam logic [7:0] REG_DIRC   = 8'h09;
    localparam logic [7:0] REG_PD     = 8'h0a;
    localparam logic [7:0] REG_DIRD   = 8'h0b;

    localparam logic [7:0] CTRL_FLAGS    = 8'h2a;
    localparam logic [7:0] CTRL_FLAG0    = 8'h02;
    localparam logic [7:0] TCTL_ACTIVE   = 8'h80;
    localparam logic [7:0] TCTL_EVENT    = 8'h40;
    localparam logic [4:0] TCTL_PRESCALE = 5'h1f;

    localparam logic [1:0] LINE_TIMER   = 2'd1;
    localparam logic [1:0] LINE_CAPTURE = 2'd2;

    function automatic logic [15:0] irq_vector_of(input logic [1:0] idx);
        logic [15:0] vec;
        case (idx)
            2'd0:    vec = 16'hfffc;
            2'd1:    vec = 16'hfffa;
            2'd2:    vec = 16'hfff8;
            default: vec = 16'h0000;
        endcase
        return vec;
    endfunction

endpackage

[rtl/core/mcu_peripheral_file_timer_irq.sv]
// Peripheral register file with timer 1 and interrupt selection.
// Input channel (i_s_*): one transfer per item. tuser carries the item kind:
// bus read, bus write, system clock tick, event pulse or interrupt line change.
// tdata carries the register offset, write byte, line select and level, the
// global enable and the pin levels of ports A, C and D.
// Output channel (o_m_*): exactly one transfer per input item, in order, with
// read data, the latched port B/C/D values, the winning interrupt request with
// its index and vector, and the timer underflow flag.
// Each item passes the middle stage and then the output register. Throughput:
// one item per cycle while the output is taken; each item updates its state when taken.
// The general registers sit in a single-port RAM with a registered read; the
// control, timer and port registers sit in flip-flops. Each RAM entry has a
// valid bit, so an entry never written reads as zero without a clearing pass.
// Reset: synchronous, active low; the control, timer and port registers, counters,
// lines and valid bits clear, and both pipeline stages empty.
// Stall: a held output keeps its transfer; one more item enters the middle
// stage, after which o_s_tready drops until the output is taken.
module mcu_peripheral_file_timer_irq
    import mpft_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // reg_offset[7:0], wdata[15:8], line_sel[17:16], line_level[18],
    // global_enable[19], port_a_pins[27:20], port_c_pins[35:28], port_d_pins[43:36]
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // func[2:0]
    input  logic [IN_USER_W-1:0]  i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // rdata[7:0], port_b_out[15:8], port_c_out[23:16], port_d_out[31:24],
    // irq_request[32], irq_index[34:33], irq_vector[50:35], timer_underflow[51]
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    logic [7:0]  w_off, w_wdata, w_pa, w_pc, w_pd;
    logic [1:0]  w_sel;
    logic        w_level, w_gie;
    t_func       w_func;

    assign w_off   = i_s_tdata[7:0];
    assign w_wdata = i_s_tdata[15:8];
    assign w_sel   = i_s_tdata[17:16];
    assign w_level = i_s_tdata[18];
    assign w_gie   = i_s_tdata[19];
    assign w_pa    = i_s_tdata[27:20];
    assign w_pc    = i_s_tdata[35:28];
    assign w_pd    = i_s_tdata[43:36];
    assign w_func  = t_func'(i_s_tuser);

    logic [7:0] r_ctrl, r_reload, r_tctl, r_pb, r_pc, r_dirc, r_pd, r_dird;
    logic [4:0] r_pre;
    logic [7:0] r_dec, r_cap;
    logic [2:0] r_lines;
    logic [7:0] n_ctrl, n_reload, n_tctl, n_pb, n_pc, n_dirc, n_pd, n_dird;
    logic [4:0] n_pre;
    logic [7:0] n_dec, n_cap;
    logic [2:0] n_lines;

    logic [7:0]        mem [PERIPH_DEPTH];
    logic [PERIPH_DEPTH-1:0] r_valid;
    logic [ADDR_W-1:0] w_idx;
    logic              w_in_range;
    logic              w_mem_we;
    logic              w_use_mem;
    logic [7:0]        w_rd;
    logic              w_under;
    logic              w_req;
    logic [1:0]        w_irq_idx;
    logic [2:0]        w_pending;

    logic        w_acc, w_out_ready, w_s1_adv;
    logic        r_s1_valid, r_s1_use_mem, r_mem_vld, r_s1_req, r_s1_under;
    logic [7:0]  r_s1_rd, r_mem_q, r_s1_pb, r_s1_pc, r_s1_pd;
    logic [1:0]  r_s1_idx;
    logic        r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [7:0]  w_s1_rdata;

    assign w_idx      = w_off[ADDR_W-1:0];
    assign w_in_range = {1'b0, w_off} < 9'(PERIPH_DEPTH);

    assign w_out_ready = !r_out_valid || i_m_tready;
    assign w_s1_adv    = r_s1_valid && w_out_ready;
    assign o_s_tready  = !r_s1_valid || w_out_ready;
    assign w_acc       = i_s_tvalid && o_s_tready;

    always_comb begin
        n_ctrl    = r_ctrl;
        n_reload  = r_reload;
        n_tctl    = r_tctl;
        n_pb      = r_pb;
        n_pc      = r_pc;
        n_dirc    = r_dirc;
        n_pd      = r_pd;
        n_dird    = r_dird;
        n_pre     = r_pre;
        n_dec     = r_dec;
        n_cap     = r_cap;
        n_lines   = r_lines;
        w_mem_we  = 1'b0;
        w_use_mem = 1'b0;
        w_rd      = 8'h00;
        w_under   = 1'b0;
        unique case (w_func)
            FN_READ: begin
                if (w_in_range) begin
                    unique case (w_off)
                        REG_CTRL:   w_rd = r_ctrl;
                        REG_RELOAD: w_rd = r_dec;
                        REG_TCTL:   w_rd = r_cap;
                        REG_PA:     w_rd = w_pa;
                        REG_PB:     w_rd = r_pb;
                        REG_PC:     w_rd = (r_pc & r_dirc) | (w_pc & ~r_dirc);
                        REG_DIRC:   w_rd = r_dirc;
                        REG_PD:     w_rd = (r_pd & r_dird) | (w_pd & ~r_dird);
                        REG_DIRD:   w_rd = r_dird;
                        default:    w_use_mem = 1'b1;
                    endcase
                end
            end
            FN_WRITE: begin
                if (w_in_range) begin
                    unique case (w_off)
                        REG_CTRL:   n_ctrl = (r_ctrl & CTRL_FLAGS & ~w_wdata)
                                           | (w_wdata & ~CTRL_FLAGS);
                        REG_RELOAD: n_reload = w_wdata;
                        REG_TCTL: begin
                            n_tctl = w_wdata;
                            if ((r_tctl & TCTL_ACTIVE) == 8'h00
                                && (w_wdata & TCTL_ACTIVE) != 8'h00) begin
                                n_pre = w_wdata[4:0] & TCTL_PRESCALE;
                                n_dec = r_reload;
                            end
                        end
                        REG_PA:     ;
                        REG_PB:     n_pb = w_wdata;
                        REG_PC:     n_pc = w_wdata & r_dirc;
                        REG_DIRC:   n_dirc = w_wdata;
                        REG_PD:     n_pd = w_wdata & r_dird;
                        REG_DIRD:   n_dird = w_wdata;
                        default:    w_mem_we = 1'b1;
                    endcase
                end
            end
            FN_TICK, FN_EVENT: begin
                if (((r_tctl & TCTL_EVENT) != 8'h00) == (w_func == FN_EVENT)
                    && (r_tctl & TCTL_ACTIVE) != 8'h00) begin
                    if (r_pre != 5'd0) begin
                        n_pre = r_pre - 5'd1;
                    end else begin
                        n_pre = r_tctl[4:0] & TCTL_PRESCALE;
                        if (r_dec != 8'h00) begin
                            n_dec = r_dec - 8'd1;
                        end else begin
                            n_dec   = r_reload;
                            w_under = 1'b1;
                            n_lines[LINE_TIMER] = 1'b1;
                            n_ctrl  = r_ctrl | (CTRL_FLAG0 << {LINE_TIMER, 1'b0});
                        end
                    end
                end
            end
            FN_LINE: begin
                if (w_sel != 2'd3) begin
                    n_lines[w_sel] = w_level;
                    if (w_level) begin
                        n_ctrl = r_ctrl | (CTRL_FLAG0 << {w_sel, 1'b0});
                        if (w_sel == LINE_CAPTURE) begin
                            n_cap = r_dec;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    assign w_pending = n_lines & {n_ctrl[4], n_ctrl[2], n_ctrl[0]}
                       & {3{w_gie}};

    always_comb begin
        w_req     = 1'b1;
        w_irq_idx = 2'd0;
        if (w_pending[0]) begin
            w_irq_idx = 2'd0;
        end else if (w_pending[1]) begin
            w_irq_idx = 2'd1;
        end else if (w_pending[2]) begin
            w_irq_idx = 2'd2;
        end else begin
            w_req = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_mem_we) begin
            mem[w_idx] <= w_wdata;
        end
        if (w_acc) begin
            r_mem_q <= mem[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_mem_vld <= 1'b0;
        end else if (w_acc) begin
            r_mem_vld <= r_valid[w_idx];
            if (w_mem_we) begin
                r_valid[w_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl   <= '0;
            r_reload <= '0;
            r_tctl   <= '0;
            r_pb     <= '0;
            r_pc     <= '0;
            r_dirc   <= '0;
            r_pd     <= '0;
            r_dird   <= '0;
            r_pre    <= '0;
            r_dec    <= '0;
            r_cap    <= '0;
            r_lines  <= '0;
        end else if (w_acc) begin
            r_ctrl   <= n_ctrl;
            r_reload <= n_reload;
            r_tctl   <= n_tctl;
            r_pb     <= n_pb;
            r_pc     <= n_pc;
            r_dirc   <= n_dirc;
            r_pd     <= n_pd;
            r_dird   <= n_dird;
            r_pre    <= n_pre;
            r_dec    <= n_dec;
            r_cap    <= n_cap;
            r_lines  <= n_lines;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_use_mem <= w_use_mem;
            r_s1_rd      <= w_rd;
            r_s1_pb      <= n_pb;
            r_s1_pc      <= n_pc;
            r_s1_pd      <= n_pd;
            r_s1_req     <= w_req;
            r_s1_idx     <= w_irq_idx;
            r_s1_under   <= w_under;
        end
    end

    assign w_s1_rdata = r_s1_use_mem ? (r_mem_vld ? r_mem_q : 8'h00) : r_s1_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_data <= {4'h0, r_s1_under,
                           r_s1_req ? irq_vector_of(r_s1_idx) : 16'h0000,
                           r_s1_req ? r_s1_idx : 2'd0, r_s1_req,
                           r_s1_pd, r_s1_pc, r_s1_pb, w_s1_rdata};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_no_req_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[32] |-> o_m_tdata[50:33] == 18'h0)
        else $error("index or vector set without a request");

    a_req_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[32]
        |-> o_m_tdata[50:35] == irq_vector_of(o_m_tdata[34:33])
            && o_m_tdata[34:33] != 2'd3)
        else $error("vector does not match winning line");

    a_ports_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc & ~r_dirc) == 8'h00 |=> (r_pc & ~r_dirc) == 8'h00
            || $past(w_acc && w_func == FN_WRITE && w_off == REG_DIRC))
        else $error("port C latch holds bits outside its direction mask");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !r_s1_valid)
        else $error("pipeline not empty after reset");

endmodule
